>>> rtl/core/md5_pkg.sv
package md5_pkg;

    // Initial chaining words, word 0 in the low bits.
    localparam logic [31:0] IV0 = 32'h67452301;
    localparam logic [31:0] IV1 = 32'hefcdab89;
    localparam logic [31:0] IV2 = 32'h98badcfe;
    localparam logic [31:0] IV3 = 32'h10325476;
    localparam logic [3:0][31:0] MD5_IV = {IV3, IV2, IV1, IV0};

    // Block geometry and padding codes.
    localparam int          BLOCK_WORDS = 16;
    localparam int          WIDX_W      = $clog2(BLOCK_WORDS);
    localparam logic [WIDX_W-1:0] LEN_LO_IDX = WIDX_W'(BLOCK_WORDS - 2);
    localparam logic [WIDX_W-1:0] LEN_HI_IDX = WIDX_W'(BLOCK_WORDS - 1);
    localparam logic [7:0]  PAD_BYTE    = 8'h80;

    // Sequencer cycles of one compression pass.
    localparam logic [6:0]  CYC_PRE     = 7'd1;
    localparam logic [6:0]  CYC_FIRST   = 7'd2;
    localparam logic [6:0]  CYC_LAST    = 7'd65;
    localparam logic [6:0]  CYC_ADD     = 7'd66;

    // Additive constants of the 64 steps.
    localparam logic [31:0] ROUND_K [64] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    // Rotate amounts, indexed by quarter and step modulo four.
    localparam logic [4:0] ROT_AMT [16] = '{
        5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
        5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
    };

    // Control from the sequencer to the compression unit.
    typedef struct packed {
        logic start;
        logic init;
    } comp_ctrl_t;

    // Status from the compression unit.
    typedef struct packed {
        logic busy;
        logic done;
    } comp_stat_t;

    // Message word used by a step.
    function automatic logic [3:0] msg_index(input logic [5:0] step);
        logic [3:0] j;
        logic [3:0] g;
        j = step[3:0];
        case (step[5:4])
            2'd0:    g = j;
            2'd1:    g = (j * 4'd5) + 4'd1;
            2'd2:    g = (j * 4'd3) + 4'd5;
            2'd3:    g = j * 4'd7;
            default: g = j;
        endcase
        return g;
    endfunction

    // Rotate amount of a step.
    function automatic logic [4:0] rot_amount(input logic [5:0] step);
        return ROT_AMT[{step[5:4], step[1:0]}];
    endfunction

    // Boolean function of a step.
    function automatic logic [31:0] step_func(input logic [5:0] step,
                                              input logic [31:0] b,
                                              input logic [31:0] c,
                                              input logic [31:0] d);
        logic [31:0] f;
        case (step[5:4])
            2'd0:    f = (b & c) | (~b & d);
            2'd1:    f = (b & d) | (c & ~d);
            2'd2:    f = b ^ c ^ d;
            2'd3:    f = c ^ (b | ~d);
            default: f = b ^ c ^ d;
        endcase
        return f;
    endfunction

    // Left rotate by a nonzero amount.
    function automatic logic [31:0] rotl32(input logic [31:0] v, input logic [4:0] s);
        logic [63:0] x;
        x = {v, v} << s;
        return x[63:32];
    endfunction

endpackage

>>> rtl/core/md5_hash_engine.sv
// Channel   Ports                                        Moves
// s_        s_data_word, s_valid_bytes, s_last_word      message word, byte count, last mark
// m_        m_digest_half, m_half_index, m_last_result   digest in two 64-bit halves
//
// A word that neither completes a block nor is the last keeps the input ready. The word
// that completes a block starts a compression that holds the input off (fetch and
// pre-add of the first word, 64 steps at one a cycle, the chaining add, the hand back).
// A last word then writes the padding words, runs one or two compressions and loads
// the digest into the output register; that load waits while the previous digest
// still occupies the register. Reset clears the control state and loads the initial
// vector; the block memory needs no clearing.
module md5_hash_engine (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_data_word,
    input  logic [2:0]  s_valid_bytes,
    input  logic        s_last_word,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [63:0] m_digest_half,
    output logic        m_half_index,
    output logic        m_last_result
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_COMP,
        ST_PAD,
        ST_FILL,
        ST_DIGEST
    } state_t;

    typedef enum logic [1:0] {
        RET_IDLE,
        RET_PAD,
        RET_FILL,
        RET_DIGEST
    } ret_t;

    state_t      state_reg, state_next;
    ret_t        ret_reg, ret_next;
    logic [5:0]  fill_reg, fill_next;
    logic [31:0] partial_reg, partial_next;
    logic [63:0] msg_bytes_reg, msg_bytes_next;
    logic [3:0]  ptr_reg, ptr_next;
    logic        extra_reg, extra_next;

    logic [127:0] obuf_reg, obuf_next;
    logic         ovalid_reg, ovalid_next;
    logic         ohalf_reg, ohalf_next;

    logic                ram_we;
    logic [3:0]          ram_waddr;
    logic [31:0]         ram_wdata;
    logic [3:0]          ram_raddr;
    logic [31:0]         ram_rdata;
    md5_pkg::comp_ctrl_t comp_ctrl;
    md5_pkg::comp_stat_t comp_stat;
    logic [3:0][31:0]    chain;

    logic [2:0]  nbytes;
    logic [1:0]  lane;
    logic [3:0]  widx;
    logic [31:0] data_masked;
    logic [63:0] window;
    logic [3:0]  total;
    logic        word_done;
    logic [63:0] bit_len;
    logic        in_xfer;
    logic        out_xfer;

    md5_block_ram #(
        .ADDR_W (md5_pkg::WIDX_W),
        .DATA_W (32)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    md5_compress u_comp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (comp_ctrl),
        .rdata   (ram_rdata),
        .raddr   (ram_raddr),
        .stat    (comp_stat),
        .chain   (chain)
    );

    assign s_ready  = (state_reg == ST_IDLE);
    assign in_xfer  = s_valid && s_ready;
    assign out_xfer = ovalid_reg && m_ready;

    // Byte packing: new bytes land after those already held in the partial word.
    assign nbytes      = (s_valid_bytes > 3'd4) ? 3'd4 : s_valid_bytes;
    assign lane        = fill_reg[1:0];
    assign widx        = fill_reg[5:2];
    assign data_masked = s_data_word & {{8{nbytes > 3'd3}}, {8{nbytes > 3'd2}},
                                        {8{nbytes > 3'd1}}, {8{nbytes > 3'd0}}};
    assign window      = {32'd0, partial_reg} | ({32'd0, data_masked} << {lane, 3'b000});
    assign total       = {2'b00, lane} + {1'b0, nbytes};
    assign word_done   = (total >= 4'd4);
    assign bit_len     = msg_bytes_reg << 3;

    // Sequencer next state.
    always_comb begin
        state_next     = state_reg;
        ret_next       = ret_reg;
        fill_next      = fill_reg;
        partial_next   = partial_reg;
        msg_bytes_next = msg_bytes_reg;
        ptr_next       = ptr_reg;
        extra_next     = extra_reg;
        obuf_next      = obuf_reg;
        ovalid_next    = ovalid_reg;
        ohalf_next     = ohalf_reg;
        ram_we         = 1'b0;
        ram_waddr      = widx;
        ram_wdata      = window[31:0];
        comp_ctrl      = '0;

        // Output register drains one half per transfer.
        if (out_xfer) begin
            if (ohalf_reg) begin
                ovalid_next = 1'b0;
                ohalf_next  = 1'b0;
            end else begin
                ohalf_next = 1'b1;
            end
        end

        case (state_reg)
            ST_IDLE: begin
                if (in_xfer) begin
                    fill_next      = fill_reg + {3'b000, nbytes};
                    msg_bytes_next = msg_bytes_reg + {61'd0, nbytes};
                    if (word_done) begin
                        ram_we       = 1'b1;
                        partial_next = window[63:32];
                    end else begin
                        partial_next = window[31:0];
                    end
                    if (word_done && widx == md5_pkg::LEN_HI_IDX) begin
                        comp_ctrl.start = 1'b1;
                        ret_next        = s_last_word ? RET_PAD : RET_IDLE;
                        state_next      = ST_COMP;
                    end else if (s_last_word) begin
                        state_next = ST_PAD;
                    end
                end
            end
            ST_PAD: begin
                // Pad byte at the current position; the tail of the word is zero.
                ram_we     = 1'b1;
                ram_wdata  = partial_reg | ({24'd0, md5_pkg::PAD_BYTE} << {lane, 3'b000});
                extra_next = (widx >= md5_pkg::LEN_LO_IDX);
                if (widx == md5_pkg::LEN_HI_IDX) begin
                    comp_ctrl.start = 1'b1;
                    ret_next        = RET_FILL;
                    extra_next      = 1'b0;
                    ptr_next        = '0;
                    state_next      = ST_COMP;
                end else begin
                    ptr_next   = widx + 4'd1;
                    state_next = ST_FILL;
                end
            end
            ST_FILL: begin
                // Zero words, with the bit length in the last two of the final block.
                ram_we    = 1'b1;
                ram_waddr = ptr_reg;
                if (!extra_reg && ptr_reg == md5_pkg::LEN_LO_IDX) begin
                    ram_wdata = bit_len[31:0];
                end else if (!extra_reg && ptr_reg == md5_pkg::LEN_HI_IDX) begin
                    ram_wdata = bit_len[63:32];
                end else begin
                    ram_wdata = '0;
                end
                if (ptr_reg == md5_pkg::LEN_HI_IDX) begin
                    comp_ctrl.start = 1'b1;
                    ret_next        = extra_reg ? RET_FILL : RET_DIGEST;
                    extra_next      = 1'b0;
                    ptr_next        = '0;
                    state_next      = ST_COMP;
                end else begin
                    ptr_next = ptr_reg + 4'd1;
                end
            end
            ST_COMP: begin
                if (comp_stat.done) begin
                    case (ret_reg)
                        RET_IDLE:   state_next = ST_IDLE;
                        RET_PAD:    state_next = ST_PAD;
                        RET_FILL:   state_next = ST_FILL;
                        RET_DIGEST: state_next = ST_DIGEST;
                        default:    state_next = ST_IDLE;
                    endcase
                end
            end
            ST_DIGEST: begin
                // Hand the digest to the output register and restart the message.
                if (!ovalid_reg) begin
                    obuf_next      = chain;
                    ovalid_next    = 1'b1;
                    ohalf_next     = 1'b0;
                    comp_ctrl.init = 1'b1;
                    msg_bytes_next = '0;
                    partial_next   = '0;
                    fill_next      = '0;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            ret_reg       <= RET_IDLE;
            fill_reg      <= '0;
            partial_reg   <= '0;
            msg_bytes_reg <= '0;
            ptr_reg       <= '0;
            extra_reg     <= 1'b0;
            ovalid_reg    <= 1'b0;
            ohalf_reg     <= 1'b0;
        end else begin
            state_reg     <= state_next;
            ret_reg       <= ret_next;
            fill_reg      <= fill_next;
            partial_reg   <= partial_next;
            msg_bytes_reg <= msg_bytes_next;
            ptr_reg       <= ptr_next;
            extra_reg     <= extra_next;
            ovalid_reg    <= ovalid_next;
            ohalf_reg     <= ohalf_next;
        end
        obuf_reg <= obuf_next;
    end

    assign m_valid       = ovalid_reg;
    assign m_digest_half = ohalf_reg ? obuf_reg[127:64] : obuf_reg[63:0];
    assign m_half_index  = ohalf_reg;
    assign m_last_result = ohalf_reg;

endmodule

>>> rtl/core/md5_block_ram.sv
module md5_block_ram #(
    parameter int ADDR_W = 4,
    parameter int DATA_W = 32
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [2**ADDR_W];
    logic [DATA_W-1:0] rdata_reg;

    // One write port, one registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/core/md5_compress.sv
module md5_compress (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  md5_pkg::comp_ctrl_t   ctrl,
    input  logic [31:0]           rdata,
    output logic [3:0]            raddr,
    output md5_pkg::comp_stat_t   stat,
    output logic [3:0][31:0]      chain
);

    logic [6:0]       cyc_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [31:0]      a_reg, b_reg, c_reg, d_reg;
    logic [31:0]      pre_reg;
    logic [3:0][31:0] chain_reg;

    logic [5:0]       step;
    logic [5:0]       step_nx;
    logic [31:0]      sum;
    logic [31:0]      t_new;

    // The read address runs ahead of the step in work by the RAM read register and the pre-add register.
    assign step    = 6'(cyc_reg - md5_pkg::CYC_FIRST);
    assign step_nx = step + 6'd1;
    assign raddr   = md5_pkg::msg_index(cyc_reg[5:0]);

    // One step: pre-added a + K + M, then function, rotate and add of b.
    assign sum   = pre_reg + md5_pkg::step_func(step, b_reg, c_reg, d_reg);
    assign t_new = b_reg + md5_pkg::rotl32(sum, md5_pkg::rot_amount(step));

    // Step sequencer and chaining words.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            cyc_reg   <= '0;
            chain_reg <= md5_pkg::MD5_IV;
        end else begin
            done_reg <= 1'b0;
            if (!busy_reg) begin
                if (ctrl.init) begin
                    chain_reg <= md5_pkg::MD5_IV;
                end
                if (ctrl.start) begin
                    busy_reg <= 1'b1;
                    cyc_reg  <= '0;
                    a_reg    <= chain_reg[0];
                    b_reg    <= chain_reg[1];
                    c_reg    <= chain_reg[2];
                    d_reg    <= chain_reg[3];
                end
            end else begin
                cyc_reg <= cyc_reg + 7'd1;
                if (cyc_reg == md5_pkg::CYC_PRE) begin
                    pre_reg <= a_reg + md5_pkg::ROUND_K[0] + rdata;
                end else if (cyc_reg >= md5_pkg::CYC_FIRST &&
                             cyc_reg <= md5_pkg::CYC_LAST) begin
                    // The next step's a is the present d.
                    pre_reg <= d_reg + md5_pkg::ROUND_K[step_nx] + rdata;
                    a_reg   <= d_reg;
                    b_reg   <= t_new;
                    c_reg   <= b_reg;
                    d_reg   <= c_reg;
                end else if (cyc_reg == md5_pkg::CYC_ADD) begin
                    chain_reg[0] <= chain_reg[0] + a_reg;
                    chain_reg[1] <= chain_reg[1] + b_reg;
                    chain_reg[2] <= chain_reg[2] + c_reg;
                    chain_reg[3] <= chain_reg[3] + d_reg;
                    busy_reg     <= 1'b0;
                    done_reg     <= 1'b1;
                end
            end
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign chain     = chain_reg;

endmodule
